FILE: design/cndm_pkg.sv
// shared types and constants for the column nearest depth mean block
`default_nettype none

package cndm_pkg;

    localparam int DEPTH_W           = 16;
    localparam int COL_IDX_W         = 9;
    localparam int NEAREST_COUNT_DEF = 10;
    localparam int COLUMN_COUNT_DEF  = 320;

    typedef logic [DEPTH_W-1:0]   depth_t;
    typedef logic [COL_IDX_W-1:0] col_idx_t;

    typedef struct packed {
        logic   valid;
        depth_t value;
    } slot_t;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_DIVIDE,
        ST_DELIVER
    } state_t;

endpackage

`default_nettype wire

FILE: design/cndm_in_if.sv
// sample channel carrying one depth pixel per item
`default_nettype none

interface cndm_in_if;
    logic                   valid;
    logic                   ready;
    cndm_pkg::depth_t       depth;
    logic                   last_in_column;

    modport source (output valid, depth, last_in_column, input ready);
    modport sink   (input valid, depth, last_in_column, output ready);
endinterface

`default_nettype wire

FILE: design/cndm_out_if.sv
// result channel carrying one column mean per item
`default_nettype none

interface cndm_out_if;
    logic                   valid;
    logic                   ready;
    cndm_pkg::col_idx_t     column_index;
    cndm_pkg::depth_t       nearest_depth;
    logic                   no_valid_depth;

    modport source (output valid, column_index, nearest_depth, no_valid_depth, input ready);
    modport sink   (input valid, column_index, nearest_depth, no_valid_depth, output ready);
endinterface

`default_nettype wire

FILE: design/column_nearest_depth_mean.sv
// top level: mean of the nearest depths of each image column
//
//   channel   role    payload                                       accepted at
//   samples   sink    depth, last_in_column                         valid & ready
//   results   source  column_index, nearest_depth, no_valid_depth   valid & ready
//
// one sample per cycle inside a column; each nonzero sample moves the sorted cell chain
// the last sample of a column starts the divider on the final sum and count,
// then the state machine closes the divide and loads the output register once it is free
// samples.ready is low while the divider runs and until the result is loaded
// reset clears the cells, the running sum, the count and the column counter
`default_nettype none

module column_nearest_depth_mean #(
    parameter int NEAREST_COUNT = cndm_pkg::NEAREST_COUNT_DEF,
    parameter int COLUMN_COUNT  = cndm_pkg::COLUMN_COUNT_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    cndm_in_if.sink     samples,
    cndm_out_if.source  results
);

    localparam int CNT_W = $clog2(NEAREST_COUNT + 1);
    localparam int SUM_W = cndm_pkg::DEPTH_W + CNT_W;
    localparam int COL_W = (COLUMN_COUNT > 1) ? $clog2(COLUMN_COUNT) : 1;

    cndm_pkg::slot_t    chain [NEAREST_COUNT+1];
    cndm_pkg::state_t   state_reg;
    cndm_pkg::state_t   state_next;

    logic [SUM_W-1:0]   sum_reg;
    logic [SUM_W-1:0]   sum_next;
    logic [SUM_W-1:0]   sum_upd;
    logic [SUM_W-1:0]   final_sum;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [CNT_W-1:0]   count_upd;
    logic [CNT_W-1:0]   final_count;
    logic [COL_W-1:0]   col_reg;
    logic [COL_W-1:0]   col_next;
    logic [COL_W-1:0]   col_hold_reg;
    logic               empty_hold_reg;

    logic               accept;
    logic               take;
    logic               column_end;
    logic               evict;
    logic               div_start;
    logic               div_busy;
    logic [SUM_W-1:0]   quotient;
    logic               out_load;
    logic               slot_free;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    cndm_pkg::col_idx_t     out_col_reg;
    cndm_pkg::depth_t       out_mean_reg;
    logic                   out_empty_reg;

    // left end of the chain acts as minus infinity
    assign chain[0] = '{valid: 1'b1, value: '0};

    assign accept     = samples.valid && samples.ready;
    assign take       = accept && (samples.depth != '0);
    assign column_end = accept && samples.last_in_column;

    for (genvar i = 0; i < NEAREST_COUNT; i++)
    begin : g_cell
        cndm_cell u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .insert (take),
            .clear  (column_end),
            .depth  (samples.depth),
            .prev   (chain[i]),
            .slot   (chain[i+1])
        );
    end

    // running sum tracks the kept set: add the new depth, drop the evicted one
    // once the chain is full a depth is added only when it evicts
    always_comb
    begin
        evict     = chain[NEAREST_COUNT].valid &&
                    (samples.depth < chain[NEAREST_COUNT].value);
        sum_upd   = sum_reg
                    + ((!chain[NEAREST_COUNT].valid || evict) ? SUM_W'(samples.depth) : '0)
                    - (evict ? SUM_W'(chain[NEAREST_COUNT].value) : '0);
        count_upd = (count_reg == CNT_W'(NEAREST_COUNT)) ? count_reg
                    : count_reg + CNT_W'(1);
        final_sum   = take ? sum_upd : sum_reg;
        final_count = take ? count_upd : count_reg;

        sum_next   = sum_reg;
        count_next = count_reg;
        col_next   = col_reg;
        priority if (column_end)
        begin
            sum_next   = '0;
            count_next = '0;
            col_next   = (col_reg == COL_W'(COLUMN_COUNT - 1)) ? '0
                         : col_reg + COL_W'(1);
        end
        else if (take)
        begin
            sum_next   = sum_upd;
            count_next = count_upd;
        end
        else
        begin
            sum_next   = sum_reg;
            count_next = count_reg;
        end
    end

    cndm_div #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (final_sum),
        .divisor  (final_count),
        .busy     (div_busy),
        .quotient (quotient)
    );

    assign slot_free = !out_valid_reg || results.ready;

    always_comb
    begin
        state_next    = state_reg;
        samples.ready = 1'b0;
        div_start     = 1'b0;
        out_load      = 1'b0;
        unique case (state_reg)
            cndm_pkg::ST_RUN:
            begin
                samples.ready = 1'b1;
                if (column_end)
                begin
                    div_start  = 1'b1;
                    state_next = cndm_pkg::ST_DIVIDE;
                end
            end
            cndm_pkg::ST_DIVIDE:
            begin
                if (!div_busy)
                begin
                    state_next = cndm_pkg::ST_DELIVER;
                end
            end
            cndm_pkg::ST_DELIVER:
            begin
                if (slot_free)
                begin
                    out_load   = 1'b1;
                    state_next = cndm_pkg::ST_RUN;
                end
            end
            default:
            begin
                state_next = cndm_pkg::ST_RUN;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        priority if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cndm_pkg::ST_RUN;
            sum_reg       <= '0;
            count_reg     <= '0;
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            col_reg       <= col_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (column_end)
        begin
            col_hold_reg   <= col_reg;
            empty_hold_reg <= (final_count == '0);
        end
        if (out_load)
        begin
            out_col_reg   <= cndm_pkg::col_idx_t'(col_hold_reg);
            out_mean_reg  <= empty_hold_reg ? '0 : cndm_pkg::DEPTH_W'(quotient);
            out_empty_reg <= empty_hold_reg;
        end
    end

    assign results.valid          = out_valid_reg;
    assign results.column_index   = out_col_reg;
    assign results.nearest_depth  = out_mean_reg;
    assign results.no_valid_depth = out_empty_reg;

    a_empty_mean_zero: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.no_valid_depth |-> results.nearest_depth == '0)
        else $error("empty column with nonzero mean");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(NEAREST_COUNT))
        else $error("held count above cell count");

    a_stall_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        column_end |=> !samples.ready && div_busy)
        else $error("sample taken during column mean");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> !div_busy && slot_free)
        else $error("result loaded over pending item");

endmodule

`default_nettype wire

FILE: design/cndm_cell.sv
// one slot of the sorted insertion chain of smallest depths
`default_nettype none

module cndm_cell (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              insert,
    input  wire logic              clear,
    input  wire cndm_pkg::depth_t  depth,
    input  wire cndm_pkg::slot_t   prev,
    output cndm_pkg::slot_t        slot
);

    cndm_pkg::slot_t slot_reg;
    cndm_pkg::slot_t slot_next;
    logic            less_here;
    logic            less_prev;

    always_comb
    begin
        less_here = !slot_reg.valid || (depth < slot_reg.value);
        less_prev = !prev.valid || (depth < prev.value);
        slot_next = slot_reg;
        priority if (clear)
        begin
            slot_next = '0;
        end
        else if (insert && less_here)
        begin
            // shift neighbor in, or take the new depth at the boundary
            if (less_prev)
            begin
                slot_next = prev;
            end
            else
            begin
                slot_next.valid = 1'b1;
                slot_next.value = depth;
            end
        end
        else
        begin
            slot_next = slot_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
        end
        else
        begin
            slot_reg <= slot_next;
        end
    end

    assign slot = slot_reg;

endmodule

`default_nettype wire

FILE: design/cndm_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none

module cndm_div #(
    parameter int SUM_W = 20,
    parameter int CNT_W = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [SUM_W-1:0] dividend,
    input  wire logic [CNT_W-1:0] divisor,
    output logic                  busy,
    output logic      [SUM_W-1:0] quotient
);

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0]  quo_reg;
    logic [SUM_W-1:0]  quo_next;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  rem_next;
    logic [CNT_W-1:0]  dvs_reg;
    logic [CNT_W-1:0]  dvs_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              busy_reg;
    logic              busy_next;
    logic [CNT_W:0]    rem_shift;
    logic [CNT_W:0]    diff;
    logic              fits;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[SUM_W-1]};
        fits      = rem_shift >= {1'b0, dvs_reg};
        diff      = rem_shift - {1'b0, dvs_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        priority if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            step_next = STEP_W'(SUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next  = {quo_reg[SUM_W-2:0], fits};
            rem_next  = fits ? diff[CNT_W-1:0] : rem_shift[CNT_W-1:0];
            step_next = step_reg - STEP_W'(1);
            busy_next = (step_reg != STEP_W'(1));
        end
        else
        begin
            quo_next  = quo_reg;
            busy_next = busy_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire
